### rtl/ura_pkg.sv
// Shared types and constants for the ultrasonic range alarm.
// Holds the register map, the configuration bundle and the result item layout.
// No dependencies.
`timescale 1ns / 1ps

package ura_pkg;

    localparam int PRE_LOW_W  = 8;
    localparam int TRIGGER_W  = 8;
    localparam int GAP_W      = 20;
    localparam int HOLD_W     = 23;
    localparam int SCALE_W    = 16;
    localparam int DIST_W     = 24;
    localparam int TICKS_W    = 16;
    localparam int PHASE_CNT_W = 20;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [PRE_LOW_W-1:0] PRE_LOW_RST   = 8'd3;
    localparam logic [TRIGGER_W-1:0] TRIGGER_RST   = 8'd10;
    localparam logic [GAP_W-1:0]     GAP_RST       = 20'd100000;
    localparam logic [HOLD_W-1:0]    HOLD_RST      = 23'd5000000;
    localparam logic [SCALE_W-1:0]   SCALE_RST     = 16'd1124;
    localparam logic [DIST_W-1:0]    THRESHOLD_RST = 24'd2560;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_PRE_LOW   = 3'd0,
        REG_TRIGGER   = 3'd1,
        REG_GAP       = 3'd2,
        REG_HOLD      = 3'd3,
        REG_SCALE     = 3'd4,
        REG_THRESHOLD = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [PRE_LOW_W-1:0] pre_low_us;
        logic [TRIGGER_W-1:0] trigger_us;
        logic [GAP_W-1:0]     gap_us;
        logic [HOLD_W-1:0]    hold_us;
        logic [SCALE_W-1:0]   scale_q16;
        logic [DIST_W-1:0]    threshold_q8;
    } cfg_t;

    // Packed so that trigger_level sits in bit 0.
    typedef struct packed {
        logic [DIST_W-1:0]  distance_q8;
        logic [TICKS_W-1:0] echo_ticks;
        logic               measure_done;
        logic               alarm_on;
        logic               trigger_level;
    } res_t;

    localparam int RES_W   = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int S_TDATA_W = 8;

endpackage

### rtl/ura_apb_regs.sv
// APB configuration registers of the ultrasonic range alarm.
// Depends on ura_pkg for the register map and the configuration bundle.
`timescale 1ns / 1ps

module ura_apb_regs import ura_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg,
    output logic [SCALE_W-1:0]    scale_next
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[4:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // The distance product is formed from the scale value that holds after this edge.
    assign scale_next = (wr_en && idx == REG_SCALE) ? pwdata[SCALE_W-1:0] : cfg_reg.scale_q16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pre_low_us   <= PRE_LOW_RST;
            cfg_reg.trigger_us   <= TRIGGER_RST;
            cfg_reg.gap_us       <= GAP_RST;
            cfg_reg.hold_us      <= HOLD_RST;
            cfg_reg.scale_q16    <= SCALE_RST;
            cfg_reg.threshold_q8 <= THRESHOLD_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_PRE_LOW:   cfg_reg.pre_low_us   <= pwdata[PRE_LOW_W-1:0];
                REG_TRIGGER:   cfg_reg.trigger_us   <= pwdata[TRIGGER_W-1:0];
                REG_GAP:       cfg_reg.gap_us       <= pwdata[GAP_W-1:0];
                REG_HOLD:      cfg_reg.hold_us      <= pwdata[HOLD_W-1:0];
                REG_SCALE:     cfg_reg.scale_q16    <= pwdata[SCALE_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold_q8 <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PRE_LOW:   prdata = APB_DATA_W'(cfg_reg.pre_low_us);
            REG_TRIGGER:   prdata = APB_DATA_W'(cfg_reg.trigger_us);
            REG_GAP:       prdata = APB_DATA_W'(cfg_reg.gap_us);
            REG_HOLD:      prdata = APB_DATA_W'(cfg_reg.hold_us);
            REG_SCALE:     prdata = APB_DATA_W'(cfg_reg.scale_q16);
            REG_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.threshold_q8);
            default:       prdata = '0;
        endcase
    end

endmodule

### rtl/ura_ranger.sv
// Measurement sequencer, echo counter, distance and alarm logic of the range alarm.
// Depends on ura_pkg for the configuration bundle and the result layout.
`timescale 1ns / 1ps

module ura_ranger import ura_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               echo_level,
    input  cfg_t               cfg,
    input  logic [SCALE_W-1:0] scale_next,
    output res_t               res
);

    localparam int PROD_W = COUNT_BITS + SCALE_W;
    localparam int EXT_W  = 48;

    typedef enum logic [2:0] {
        PH_PRE_LOW = 3'd0,
        PH_TRIG    = 3'd1,
        PH_WAIT    = 3'd2,
        PH_HIGH    = 3'd3,
        PH_GAP     = 3'd4
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [PHASE_CNT_W-1:0]  phase_count_reg, phase_count_next;
    logic [COUNT_BITS-1:0]   echo_count_reg, echo_count_next;
    logic [DIST_W-1:0]       distance_reg, distance_next;
    logic                    alarm_reg, alarm_next;
    logic [HOLD_W-1:0]       hold_reg, hold_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;

    logic [EXT_W-1:0]        prod_ext;
    logic [DIST_W-1:0]       dist_sat;
    logic [DIST_W-1:0]       cnt_ext;
    logic                    trig;
    logic                    done;
    logic                    close_reading;

    // Product of the count held in the state and the scale, registered ahead of the tick
    // on which the echo falls, so that this tick only saturates and compares.
    assign prod_ext = EXT_W'(prod_reg);
    assign dist_sat = (|prod_ext[EXT_W-1:32]) ? '1 : prod_ext[31:8];

    always_comb begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        echo_count_next  = echo_count_reg;
        distance_next    = distance_reg;
        alarm_next       = alarm_reg;
        hold_next        = hold_reg;
        trig             = 1'b0;
        done             = 1'b0;
        close_reading    = 1'b0;

        if (phase_reg > PH_GAP) begin
            phase_next       = PH_PRE_LOW;
            phase_count_next = '0;
        end

        // Phases whose length is already met end before this tick is spent.
        if (phase_next == PH_GAP && phase_count_next >= cfg.gap_us) begin
            phase_next       = PH_PRE_LOW;
            phase_count_next = '0;
        end
        if (phase_next == PH_PRE_LOW && phase_count_next >= PHASE_CNT_W'(cfg.pre_low_us)) begin
            phase_next       = PH_TRIG;
            phase_count_next = '0;
        end
        if (phase_next == PH_TRIG && phase_count_next >= PHASE_CNT_W'(cfg.trigger_us)) begin
            phase_next       = PH_WAIT;
            phase_count_next = '0;
        end

        unique case (phase_next)
            PH_PRE_LOW: begin
                phase_count_next = phase_count_next + 1'b1;
            end
            PH_TRIG: begin
                trig             = 1'b1;
                phase_count_next = phase_count_next + 1'b1;
            end
            PH_WAIT: begin
                if (echo_level) begin
                    echo_count_next = COUNT_BITS'(1);
                    phase_next      = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (echo_level) begin
                    if (!(&echo_count_reg)) begin
                        echo_count_next = echo_count_reg + 1'b1;
                    end
                end else begin
                    distance_next    = dist_sat;
                    done             = 1'b1;
                    phase_next       = PH_GAP;
                    phase_count_next = '0;
                    if (dist_sat < cfg.threshold_q8) begin
                        alarm_next    = 1'b1;
                        hold_next     = '0;
                        close_reading = 1'b1;
                    end
                    if (alarm_next && hold_next >= cfg.hold_us) begin
                        alarm_next = 1'b0;
                    end
                end
            end
            PH_GAP: begin
                if (!(&phase_count_next)) begin
                    phase_count_next = phase_count_next + 1'b1;
                end
            end
            default: ;
        endcase

        if (alarm_next && !close_reading && !(&hold_next)) begin
            hold_next = hold_next + 1'b1;
        end
    end

    always_comb begin
        if (step) begin
            prod_next = PROD_W'(echo_count_next) * PROD_W'(scale_next);
        end else begin
            prod_next = PROD_W'(echo_count_reg) * PROD_W'(scale_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PRE_LOW;
            phase_count_reg <= '0;
            echo_count_reg  <= '0;
            distance_reg    <= '0;
            alarm_reg       <= 1'b0;
            hold_reg        <= '0;
            prod_reg        <= '0;
        end else begin
            prod_reg <= prod_next;
            if (step) begin
                phase_reg       <= phase_next;
                phase_count_reg <= phase_count_next;
                echo_count_reg  <= echo_count_next;
                distance_reg    <= distance_next;
                alarm_reg       <= alarm_next;
                hold_reg        <= hold_next;
            end
        end
    end

    assign cnt_ext = DIST_W'(echo_count_next);

    always_comb begin
        res.trigger_level = trig;
        res.alarm_on      = alarm_next;
        res.measure_done  = done;
        res.echo_ticks    = (|cnt_ext[DIST_W-1:TICKS_W]) ? '1 : cnt_ext[TICKS_W-1:0];
        res.distance_q8   = distance_next;
    end

endmodule

### rtl/ultrasonic_range_alarm.sv
// Top level of the ultrasonic range alarm: stream ports, result register and checks.
// Depends on ura_pkg, ura_apb_regs and ura_ranger.
`timescale 1ns / 1ps

// The block drives an ultrasonic ranger of the trigger/echo kind and raises a proximity
// alarm. Feed it one transfer per microsecond tick on the s_ channel, carrying the
// sampled echo pin in s_tdata[0]; for every input transfer it returns exactly one
// result transfer on the m_ channel with the trigger pin level for that tick, the
// alarm state, a flag on the tick a measurement completes, the echo high-time count
// and the last distance in 1/256 cm. Each measurement holds the trigger low for
// pre_low_us ticks, pulses it for trigger_us ticks, waits without timeout for the
// echo to rise, counts the high ticks, and then pauses gap_us ticks. A distance
// under threshold_q8 turns the alarm on and restarts its hold timer; a completed
// measurement turns it off once hold_us ticks have passed. The block takes one
// transfer every clock cycle and the result appears in the output register on the
// following cycle; the longest path is the echo count update feeding the count times
// scale multiplier, whose product is registered ahead of the tick on which the echo
// falls. A full output register that is not taken stalls s_tready, and the next
// transfer is accepted in the same cycle the waiting result leaves. The registers sit
// on an APB port at byte addresses 0x00 to 0x14 and should be written only while no
// transfer is in flight.

module ultrasonic_range_alarm import ura_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [0] echo_level, rest zero

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] trigger_level, [1] alarm_on, [2] measure_done, [18:3] echo_ticks,
    // [42:19] distance_q8, rest zero
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t               cfg;
    logic [SCALE_W-1:0] scale_next;
    res_t               res;
    res_t               res_reg;
    logic               m_valid_reg;
    logic               s_fire;

    assign pready = 1'b1;

    ura_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cfg        (cfg),
        .scale_next (scale_next)
    );

    // The sequencer advances its state only on an accepted input transfer.
    ura_ranger #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ranger (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_fire),
        .echo_level (s_tdata[0]),
        .cfg        (cfg),
        .scale_next (scale_next),
        .res        (res)
    );

    // The output register accepts a new result whenever it is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(res_reg);

    // Every accepted transfer leaves a result in the output register.
    a_fire_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid
    ) else $error("accepted transfer produced no result");

    // A completed measurement never coincides with a trigger pulse.
    a_done_no_trigger: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.measure_done) |-> !res_reg.trigger_level
    ) else $error("measurement completed while trigger driven");

    // A completed measurement has counted at least one echo tick.
    a_done_has_ticks: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.measure_done) |-> (res_reg.echo_ticks != '0)
    ) else $error("measurement completed with zero echo ticks");

endmodule
